/* hw/rtl/nmc_pkg.sv */
// Shared types and constants for the nearest medoid classifier.
// No dependencies; imported by every module of the block that needs them.
package nmc_pkg;

    localparam int CLASS_W = 4;
    localparam int PIX_W   = 12;
    localparam int VAL_W   = 8;
    localparam int COUNT_W = 12;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    localparam int NUM_CLASSES_DEF    = 10;
    localparam int IMAGE_ELEMENTS_DEF = 2352;

    // operation codes carried on tuser
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // one item as it travels down the chain
    typedef struct packed {
        logic               valid;
        logic               op;
        logic [CLASS_W-1:0] cls;
        logic [PIX_W-1:0]   pix;
        logic               inr;   // pixel index inside the image
        logic               qbit;  // binarized pixel value
        logic               last;
    } t_item;

    // running best class and its mismatch count
    typedef struct packed {
        logic [CLASS_W-1:0] idx;
        logic [COUNT_W-1:0] cnt;
    } t_token;

    typedef struct packed {
        t_item  item;
        t_token tok;
    } t_link;

endpackage

/* hw/rtl/nmc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module nmc_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/nmc_cell.sv */
// One class cell: prototype bit column, mismatch counter and a chain stage.
// Depends on nmc_pkg and nmc_ram.
module nmc_cell #(
    parameter int CELL_IDX       = 0,
    parameter int IMAGE_ELEMENTS = nmc_pkg::IMAGE_ELEMENTS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  nmc_pkg::t_link i_link,
    output nmc_pkg::t_link o_link
);
    import nmc_pkg::*;

    localparam int ADDR_W = (IMAGE_ELEMENTS > 1) ? $clog2(IMAGE_ELEMENTS) : 1;

    t_link              r_link;
    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [COUNT_W-1:0] w_sum;
    logic               w_we;
    logic               w_proto;
    logic               w_query;
    logic               w_miss;
    logic               w_close;

    // store this class's bit of a prototype write
    assign w_we = i_link.item.valid && (i_link.item.op == OP_WRITE) && i_link.item.inr
                  && (i_link.item.cls == CLASS_W'(CELL_IDX));

    nmc_ram #(
        .WIDTH (1),
        .DEPTH (IMAGE_ELEMENTS)
    ) u_proto (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (i_link.item.pix[ADDR_W-1:0]),
        .i_wdata (i_link.item.qbit),
        .i_raddr (i_link.item.pix[ADDR_W-1:0]),
        .o_rdata (w_proto)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link  <= '0;
            r_count <= '0;
        end else begin
            r_link  <= i_link;
            r_count <= n_count;
        end
    end

    assign w_query = r_link.item.valid && (r_link.item.op == OP_QUERY);
    assign w_miss  = w_query && r_link.item.inr && (w_proto != r_link.item.qbit);
    assign w_sum   = (w_miss && (r_count != COUNT_MAX)) ? r_count + COUNT_W'(1) : r_count;
    assign w_close = w_query && r_link.item.last;

    // take over the token on a strictly smaller count, clear at image end
    always_comb begin
        o_link  = r_link;
        n_count = w_sum;
        if (w_close) begin
            n_count = '0;
            if (w_sum < r_link.tok.cnt) begin
                o_link.tok.idx = CLASS_W'(CELL_IDX);
                o_link.tok.cnt = w_sum;
            end
        end
    end

endmodule

/* hw/rtl/nmc_fifo.sv */
// Small register FIFO holding finished results for the output stream.
// No dependencies.
module nmc_fifo #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic             w_pop;

    assign w_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd <= r_rd + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(w_pop);
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd];

endmodule

/* hw/rtl/nearest_medoid_classifier_top.sv */
// Throughput: one item per cycle on the input stream while o_s_tready is high, writes and queries alike.
// A result is offered once the last query pixel has left the last class cell and passed the result FIFO.
// Every item steps through one class cell per cycle; the cell count sets the latency.
// o_s_tready drops only while the result FIFO plus results in flight fill FIFO_DEPTH.
// Reset (i_rst_n low, synchronous) clears counters, chain valids and the FIFO;
// prototype memories keep their contents and are undefined until written.
module nearest_medoid_classifier_top #(
    parameter int NUM_CLASSES    = nmc_pkg::NUM_CLASSES_DEF,
    parameter int IMAGE_ELEMENTS = nmc_pkg::IMAGE_ELEMENTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [23:0] i_s_tdata,   // [3:0] class_index, [15:4] pixel_index,
                                     // [23:16] pixel_value
    input  logic        i_s_tuser,   // [0] operation
    input  logic        i_s_tlast,   // last_pixel
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata    // [3:0] predicted_class, [15:4] best_distance_squared
);
    import nmc_pkg::*;

    // power of two so FIFO pointers wrap freely; covers the chain plus slack
    localparam int FIFO_DEPTH = 1 << $clog2(NUM_CLASSES + 4);
    localparam int PEND_W     = $clog2(FIFO_DEPTH + 1);

    t_link             w_link [NUM_CLASSES + 1];
    logic              w_in_xfer;
    logic              w_out_xfer;
    logic              w_push;
    logic              w_start;
    logic [PEND_W-1:0] r_pend;
    logic [PEND_W-1:0] n_pend;
    t_token            w_result;

    assign w_in_xfer  = i_s_tvalid && o_s_tready;
    assign w_out_xfer = o_m_tvalid && i_m_tready;

    // a query pixel that closes an image will produce one result
    assign w_start = w_in_xfer && (i_s_tuser == OP_QUERY) && i_s_tlast;

    // build the chain head: binarize the pixel, flag out-of-range indices and
    // seed the token with class zero at the largest count
    always_comb begin
        w_link[0].item.valid = w_in_xfer;
        w_link[0].item.op    = i_s_tuser;
        w_link[0].item.cls   = i_s_tdata[CLASS_W-1:0];
        w_link[0].item.pix   = i_s_tdata[CLASS_W +: PIX_W];
        w_link[0].item.inr   = {1'b0, i_s_tdata[CLASS_W +: PIX_W]}
                               < (PIX_W + 1)'(IMAGE_ELEMENTS);
        w_link[0].item.qbit  = |i_s_tdata[CLASS_W + PIX_W +: VAL_W];
        w_link[0].item.last  = i_s_tlast;
        w_link[0].tok.idx    = '0;
        w_link[0].tok.cnt    = COUNT_MAX;
    end

    // one cell per class, each registering the link from its left neighbor
    for (genvar g = 0; g < NUM_CLASSES; g++) begin : g_cell
        nmc_cell #(
            .CELL_IDX       (g),
            .IMAGE_ELEMENTS (IMAGE_ELEMENTS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_link  (w_link[g]),
            .o_link  (w_link[g + 1])
        );
    end

    // the token leaving the last cell on a closing query is the answer
    assign w_push = w_link[NUM_CLASSES].item.valid
                    && (w_link[NUM_CLASSES].item.op == OP_QUERY)
                    && w_link[NUM_CLASSES].item.last;

    nmc_fifo #(
        .WIDTH ($bits(t_token)),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_link[NUM_CLASSES].tok),
        .i_pop   (i_m_tready),
        .o_valid (o_m_tvalid),
        .o_data  (w_result)
    );

    assign o_m_tdata = {w_result.cnt, w_result.idx};

    // count results in flight or queued; hold off input when the FIFO could overflow
    assign n_pend = r_pend + PEND_W'(w_start) - PEND_W'(w_out_xfer);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= n_pend;
        end
    end

    assign o_s_tready = (r_pend < PEND_W'(FIFO_DEPTH));

`ifndef ASSERT_OFF
    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= PEND_W'(FIFO_DEPTH))
        else $error("pending result count exceeds FIFO depth");

    a_out_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_pend != '0))
        else $error("result offered without a pending image");

    a_push_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push |-> (r_pend != '0))
        else $error("result left the chain without a pending image");
`endif

endmodule
